FILE: rtl/rbnh_pkg.sv
// Shared types and constants for the ray/box nearest-hit caster.
// Request and response payloads, divider tags, command and field codes.
// No dependencies.
package rbnh_pkg;

	localparam int MAX_BOXES_DEF   = 32;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS       = 16;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	localparam logic [2:0] FIELD_MIN_X = 3'd0;
	localparam logic [2:0] FIELD_MAX_X = 3'd1;
	localparam logic [2:0] FIELD_MIN_Z = 3'd2;
	localparam logic [2:0] FIELD_MAX_Z = 3'd3;
	localparam logic [2:0] FIELD_TOP   = 3'd4;

	typedef struct packed {
		logic               command;
		logic [4:0]         box_index;
		logic [2:0]         box_field;
		logic signed [31:0] box_value;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic [30:0]        max_t;
	} req_t;

	typedef struct packed {
		logic [30:0] distance;
		logic        hit;
	} rsp_t;

	// Travels alongside each division through the cell row.
	typedef struct packed {
		logic hi;    // upper bound of a slab
		logic last;  // final division of a box
		logic flr;   // floor plane division
		logic skip;  // parallel axis or no floor: ignore quotient
		logic miss;  // parallel axis with origin outside the slab
	} div_tag_t;

endpackage

FILE: rtl/ray_box_nearest_hit.sv
// Nearest-hit ray caster over a table of axis-aligned boxes plus the floor.
// Depends on rbnh_pkg, rbnh_box_store and rbnh_div_chain.
//
// A write request (command 0) stores one field of one box; box indexes at
// or beyond MAX_BOXES and field codes above 4 store nothing. A cast request
// (command 1) runs the slab test against the first min(box_count,
// MAX_BOXES) boxes and the floor plane and yields one response. The
// division unit is a row of COORD_WIDTH+17 one-bit cells that accepts one
// division per cycle; a cast feeds it six divisions per box and one for
// the floor. Requests are held off while a cast is in flight; a finished
// response waits in its own output register, so the next request is taken
// while the previous response is still pending. The user must write
// box_count through cfg_we/cfg_wdata only while no cast is in flight; the
// block itself does not enforce this. Read only box fields that have been
// written since reset.
module ray_box_nearest_hit #(
	parameter int MAX_BOXES   = rbnh_pkg::MAX_BOXES_DEF,
	parameter int COORD_WIDTH = rbnh_pkg::COORD_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  rbnh_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output rbnh_pkg::rsp_t rsp_data,
	input  logic           cfg_we,
	input  logic [5:0]     cfg_wdata
);

	localparam int W  = COORD_WIDTH;
	localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam logic [2:0] SUB_LAST = 3'd5;
	localparam logic signed [W-1:0] TMAX = {1'b0, {(W-1){1'b1}}};

	typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN, ST_FINISH} state_t;

	state_t              state_q;
	logic [5:0]          box_count_q;
	logic [CW-1:0]       n_q;
	logic [CW-1:0]       bi_q;
	logic [2:0]          sub_q;
	logic signed [W-1:0] ox_q, oy_q, oz_q, dx_q, dy_q, dz_q;
	logic signed [W-1:0] maxt_q, best_q, t0_q, t1_q, a_q;
	logic                miss_q;

	logic                req_acc;
	logic                wr_en;
	logic [CW-1:0]       bi_next;
	logic [AW-1:0]       raddr;
	logic signed [W-1:0] rd_min_x, rd_max_x, rd_min_z, rd_max_z, rd_top;

	logic                div_vld;
	logic signed [W:0]   div_num;
	logic signed [W-1:0] div_den;
	rbnh_pkg::div_tag_t  div_tag;
	logic                dq_vld;
	logic signed [W-1:0] dq_q;
	rbnh_pkg::div_tag_t  dq_tag;

	logic signed [W-1:0] sel_o, sel_d, sel_lo, sel_hi, sel_b;
	logic signed [W-1:0] lo_v, hi_v, t0n, t1n, box_t;
	logic                missn;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign wr_en     = req_acc && (req_data.command == rbnh_pkg::CMD_WRITE)
	                   && (32'(req_data.box_index) < MAX_BOXES);

	// Read one box ahead so the row is ready when the next box starts.
	assign bi_next = bi_q + CW'(1);
	assign raddr   = (state_q == ST_ISSUE && sub_q == SUB_LAST) ? bi_next[AW-1:0]
	                                                            : bi_q[AW-1:0];

	rbnh_box_store #(.W(W), .N(MAX_BOXES), .AW(AW)) u_store (
		.clk     (clk),
		.we      (wr_en),
		.wfield  (req_data.box_field),
		.waddr   (AW'(req_data.box_index)),
		.wdata   (W'(req_data.box_value)),
		.raddr   (raddr),
		.rd_min_x(rd_min_x),
		.rd_max_x(rd_max_x),
		.rd_min_z(rd_min_z),
		.rd_max_z(rd_max_z),
		.rd_top  (rd_top)
	);

	// Pick the slab for this step: x bounds, floor..top, z bounds.
	always_comb begin
		case (sub_q)
			3'd0, 3'd1: begin
				sel_o = ox_q; sel_d = dx_q; sel_lo = rd_min_x; sel_hi = rd_max_x;
			end
			3'd2, 3'd3: begin
				sel_o = oy_q; sel_d = dy_q; sel_lo = '0; sel_hi = rd_top;
			end
			default: begin
				sel_o = oz_q; sel_d = dz_q; sel_lo = rd_min_z; sel_hi = rd_max_z;
			end
		endcase
		sel_b = sub_q[0] ? sel_hi : sel_lo;
	end

	// Issue one division a cycle; the floor goes last, after every box.
	always_comb begin
		div_vld = (state_q == ST_ISSUE);
		div_tag = '0;
		if (bi_q == n_q) begin
			div_num      = -(W+1)'(oy_q);
			div_den      = dy_q;
			div_tag.flr  = 1'b1;
			div_tag.skip = !dy_q[W-1];
		end else begin
			div_num      = (W+1)'(sel_b) - (W+1)'(sel_o);
			div_den      = sel_d;
			div_tag.hi   = sub_q[0];
			div_tag.last = (sub_q == SUB_LAST);
			div_tag.skip = (sel_d == '0);
			div_tag.miss = (sel_d == '0) && (sel_o < sel_lo || sel_o > sel_hi);
		end
	end

	rbnh_div_chain #(.W(W)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.vld_i (div_vld),
		.num_i (div_num),
		.den_i (div_den),
		.tag_i (div_tag),
		.vld_o (dq_vld),
		.q_o   (dq_q),
		.tag_o (dq_tag)
	);

	// Fold the second bound of a slab into the running entry/exit times.
	always_comb begin
		lo_v  = (a_q > dq_q) ? dq_q : a_q;
		hi_v  = (a_q > dq_q) ? a_q : dq_q;
		t0n   = (dq_tag.skip || lo_v <= t0_q) ? t0_q : lo_v;
		t1n   = (dq_tag.skip || hi_v >= t1_q) ? t1_q : hi_v;
		missn = miss_q || dq_tag.miss;
		box_t = (!missn && t1n >= t0n && t1n >= 0 && t0n > 0) ? t0n : TMAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			box_count_q <= '0;
			bi_q        <= '0;
			sub_q       <= '0;
			rsp_valid   <= 1'b0;
		end else begin
			if (cfg_we) begin
				box_count_q <= cfg_wdata;
			end
			// The finish state refills the register itself when it frees up.
			if (rsp_valid && !rsp_stall && state_q != ST_FINISH) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc && req_data.command == rbnh_pkg::CMD_CAST) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (bi_q == n_q) begin
						state_q <= ST_DRAIN;
					end else if (sub_q == SUB_LAST) begin
						sub_q <= '0;
						bi_q  <= bi_next;
					end else begin
						sub_q <= sub_q + 3'd1;
					end
				end
				ST_DRAIN: begin
					if (dq_vld && dq_tag.flr) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// Hold until the previous response has left.
					if (!rsp_valid || !rsp_stall) begin
						rsp_valid <= 1'b1;
						bi_q      <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload: cast operands, slab accumulation, best distance, response.
	always_ff @(posedge clk) begin
		if (req_acc && req_data.command == rbnh_pkg::CMD_CAST) begin
			ox_q   <= W'(req_data.origin_x);
			oy_q   <= W'(req_data.origin_y);
			oz_q   <= W'(req_data.origin_z);
			dx_q   <= W'(req_data.dir_x);
			dy_q   <= W'(req_data.dir_y);
			dz_q   <= W'(req_data.dir_z);
			maxt_q <= W'(req_data.max_t) & TMAX;
			best_q <= W'(req_data.max_t) & TMAX;
			n_q    <= (32'(box_count_q) > MAX_BOXES) ? CW'(MAX_BOXES) : CW'(box_count_q);
			t0_q   <= '0;
			t1_q   <= TMAX;
			miss_q <= 1'b0;
		end else if (dq_vld) begin
			if (dq_tag.flr) begin
				if (!dq_tag.skip && dq_q > 0 && dq_q < best_q) begin
					best_q <= dq_q;
				end
			end else if (!dq_tag.hi) begin
				a_q    <= dq_q;
				miss_q <= missn;
			end else if (dq_tag.last) begin
				if (box_t < best_q) begin
					best_q <= box_t;
				end
				t0_q   <= '0;
				t1_q   <= TMAX;
				miss_q <= 1'b0;
			end else begin
				t0_q   <= t0n;
				t1_q   <= t1n;
				miss_q <= missn;
			end
		end
		if (state_q == ST_FINISH && (!rsp_valid || !rsp_stall)) begin
			rsp_data.distance <= 31'(best_q);
			rsp_data.hit      <= (best_q < maxt_q);
		end
	end

	// A response appears only on the way out of the finish state.
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_FINISH))
		else $error("response raised outside finish");

	// The divider is empty whenever no cast is in flight.
	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		dq_vld |-> (state_q == ST_ISSUE || state_q == ST_DRAIN))
		else $error("division result with no cast in flight");

	// The box sweep never runs past the tested count.
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (bi_q <= n_q && sub_q <= SUB_LAST))
		else $error("box sweep out of range");

endmodule

FILE: rtl/rbnh_div_cell.sv
// One restoring-division step: one quotient bit per cell.
// Uses rbnh_pkg::div_tag_t; instantiated in a row by rbnh_div_chain.
module rbnh_div_cell #(
	parameter int W  = rbnh_pkg::COORD_WIDTH_DEF,
	parameter int DW = rbnh_pkg::COORD_WIDTH_DEF + 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_i,
	input  logic [W-1:0]        rem_i,
	input  logic [DW-1:0]       dq_i,
	input  logic [W-1:0]        den_i,
	input  logic                neg_i,
	input  rbnh_pkg::div_tag_t  tag_i,
	output logic                vld_o,
	output logic [W-1:0]        rem_o,
	output logic [DW-1:0]       dq_o,
	output logic [W-1:0]        den_o,
	output logic                neg_o,
	output rbnh_pkg::div_tag_t  tag_o
);

	logic [W:0] r2;
	logic [W:0] diff;
	logic       ge;

	assign r2   = {rem_i, dq_i[DW-1]};
	assign diff = r2 - {1'b0, den_i};
	assign ge   = (r2 >= {1'b0, den_i});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_o <= ge ? diff[W-1:0] : r2[W-1:0];
		dq_o  <= {dq_i[DW-2:0], ge};
		den_o <= den_i;
		neg_o <= neg_i;
		tag_o <= tag_i;
	end

endmodule

FILE: rtl/rbnh_div_chain.sv
// Pipelined Q16.16 divider built as a row of rbnh_div_cell, one bit per cell.
// Takes magnitudes on entry, saturates the signed quotient on exit.
// Depends on rbnh_pkg and rbnh_div_cell.
module rbnh_div_chain #(
	parameter int W = rbnh_pkg::COORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_i,
	input  logic signed [W:0]   num_i,
	input  logic signed [W-1:0] den_i,
	input  rbnh_pkg::div_tag_t  tag_i,
	output logic                vld_o,
	output logic signed [W-1:0] q_o,
	output rbnh_pkg::div_tag_t  tag_o
);

	localparam int DW = W + 1 + rbnh_pkg::FRAC_BITS;
	localparam logic [W-1:0] TMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] TMIN = {1'b1, {(W-1){1'b0}}};

	logic               vld [DW+1];
	logic [W-1:0]       rem [DW+1];
	logic [DW-1:0]      dq  [DW+1];
	logic [W-1:0]       den [DW+1];
	logic               neg [DW+1];
	rbnh_pkg::div_tag_t tag [DW+1];

	logic [W:0]    un;
	logic [W-1:0]  ud;
	logic [DW-1:0] quo;

	assign un = num_i[W] ? (W+1)'(-num_i) : num_i;
	assign ud = den_i[W-1] ? W'(-den_i) : den_i;

	assign vld[0] = vld_i;
	assign rem[0] = '0;
	assign dq[0]  = {un, {rbnh_pkg::FRAC_BITS{1'b0}}};
	assign den[0] = ud;
	assign neg[0] = num_i[W] ^ den_i[W-1];
	assign tag[0] = tag_i;

	for (genvar k = 0; k < DW; k++) begin : g_cell
		rbnh_div_cell #(.W(W), .DW(DW)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.vld_i (vld[k]),
			.rem_i (rem[k]),
			.dq_i  (dq[k]),
			.den_i (den[k]),
			.neg_i (neg[k]),
			.tag_i (tag[k]),
			.vld_o (vld[k+1]),
			.rem_o (rem[k+1]),
			.dq_o  (dq[k+1]),
			.den_o (den[k+1]),
			.neg_o (neg[k+1]),
			.tag_o (tag[k+1])
		);
	end

	assign quo   = dq[DW];
	assign vld_o = vld[DW];
	assign tag_o = tag[DW];

	// Saturate: the largest value also stands for infinity.
	always_comb begin
		if (!neg[DW]) begin
			q_o = (quo > DW'(TMAX)) ? TMAX : quo[W-1:0];
		end else if (quo > DW'(TMAX) + DW'(1)) begin
			q_o = TMIN;
		end else begin
			q_o = W'(-quo[W-1:0]);
		end
	end

endmodule

FILE: rtl/rbnh_box_store.sv
// Box table: five field memories written one field at a time, read a row
// at a time with registered data. Depends on rbnh_pkg for field codes.
module rbnh_box_store #(
	parameter int W  = rbnh_pkg::COORD_WIDTH_DEF,
	parameter int N  = rbnh_pkg::MAX_BOXES_DEF,
	parameter int AW = 5
) (
	input  logic                clk,
	input  logic                we,
	input  logic [2:0]          wfield,
	input  logic [AW-1:0]       waddr,
	input  logic signed [W-1:0] wdata,
	input  logic [AW-1:0]       raddr,
	output logic signed [W-1:0] rd_min_x,
	output logic signed [W-1:0] rd_max_x,
	output logic signed [W-1:0] rd_min_z,
	output logic signed [W-1:0] rd_max_z,
	output logic signed [W-1:0] rd_top
);

	logic signed [W-1:0] mem_min_x [N];
	logic signed [W-1:0] mem_max_x [N];
	logic signed [W-1:0] mem_min_z [N];
	logic signed [W-1:0] mem_max_z [N];
	logic signed [W-1:0] mem_top   [N];

	always_ff @(posedge clk) begin
		if (we) begin
			case (wfield)
				rbnh_pkg::FIELD_MIN_X: mem_min_x[waddr] <= wdata;
				rbnh_pkg::FIELD_MAX_X: mem_max_x[waddr] <= wdata;
				rbnh_pkg::FIELD_MIN_Z: mem_min_z[waddr] <= wdata;
				rbnh_pkg::FIELD_MAX_Z: mem_max_z[waddr] <= wdata;
				rbnh_pkg::FIELD_TOP:   mem_top[waddr]   <= wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_min_x <= mem_min_x[raddr];
		rd_max_x <= mem_max_x[raddr];
		rd_min_z <= mem_min_z[raddr];
		rd_max_z <= mem_max_z[raddr];
		rd_top   <= mem_top[raddr];
	end

endmodule
